// ===== sv/bbs_pkg.sv =====
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants for the beacon backoff scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package bbs_pkg;

    localparam int CMD_W     = 3;
    localparam int WORD_W    = 16;
    localparam int COUNT_W   = 8;
    localparam int SECS_W    = 17;
    localparam int BCNT_W    = 9;
    localparam int CFG_IDX_W = 8;
    localparam int DIV_STEPS = WORD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // command codes carried in the cmd field of an input beat
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_CHAN  = 3'd3,
        CMD_TX    = 3'd4
    } bbs_cmd_t;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_SPAN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKOFFS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_IDLE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IDLE     = 8'd3;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } bbs_state_t;

    typedef struct packed {
        logic [WORD_W-1:0]  backoff_span;
        logic [COUNT_W-1:0] max_backoffs;
        logic [WORD_W-1:0]  min_idle;
        logic [WORD_W-1:0]  max_idle;
    } bbs_cfg_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } bbs_div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rem;
    } bbs_div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/bbs_if.sv =====
// ----------------------------------------------------------------------------
// bbs_if
// Valid/ready channel interfaces: command beats, result beats, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbs_item_if;
    logic                      valid;
    logic                      ready;
    logic [bbs_pkg::CMD_W-1:0] cmd;
    logic                      channel_busy;
    logic                      transmitting;
    logic [bbs_pkg::WORD_W-1:0] random_word;

    modport source (output valid, cmd, channel_busy, transmitting, random_word,
                    input ready);
    modport sink   (input valid, cmd, channel_busy, transmitting, random_word,
                    output ready);
endinterface

interface bbs_result_if;
    logic valid;
    logic ready;
    logic transmit_now;
    logic started;
    logic stopped;

    modport source (output valid, transmit_now, started, stopped, input ready);
    modport sink   (input valid, transmit_now, started, stopped, output ready);
endinterface

interface bbs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bbs_pkg::CFG_IDX_W-1:0] index;
    logic [bbs_pkg::WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/beacon_backoff_scheduler.sv =====
// ----------------------------------------------------------------------------
// beacon_backoff_scheduler
// Beacon transmit scheduler with carrier-sense random backoff on second ticks.
// ----------------------------------------------------------------------------
//  port     dir   beat contents
//  items    sink  cmd, channel_busy, transmitting, random_word
//  results  src   transmit_now, started, stopped (one beat per command)
//  cfg      sink  index, data (register write, always ready)
//
//  most commands finish in the accept cycle; the result is registered and the
//  next command is taken in the cycle that result beat leaves
//  a command that draws a random delay runs the shared remainder unit, one bit
//  a cycle, and the next command is taken only after the remainder is back
//  rst_n clears the scheduler state; registers return to their reset values
//  a stalled results beat holds the items side off only until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_backoff_scheduler (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bbs_item_if.sink     items,
    bbs_result_if.source results,
    bbs_cfg_if.sink      cfg
);
    import bbs_pkg::*;

    bbs_cfg_t cfg_reg, cfg_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            // writes beyond the last register are dropped
            unique case (cfg.index)
                REG_BACKOFF_SPAN: cfg_next.backoff_span = cfg.data;
                REG_MAX_BACKOFFS: cfg_next.max_backoffs = cfg.data[COUNT_W-1:0];
                REG_MIN_IDLE:     cfg_next.min_idle     = cfg.data;
                REG_MAX_IDLE:     cfg_next.max_idle     = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.backoff_span <= WORD_W'(1);
            cfg_reg.max_backoffs <= '0;
            cfg_reg.min_idle     <= '0;
            cfg_reg.max_idle     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .items    (items),
        .results  (results)
    );

endmodule

`default_nettype wire

// ===== sv/bbs_mod.sv =====
// ----------------------------------------------------------------------------
// bbs_mod
// Shared restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_mod (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bbs_pkg::bbs_div_req_t req,
    output bbs_pkg::bbs_div_rsp_t      rsp
);
    import bbs_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] div_reg, div_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        shifted   = {rem_reg, quo_reg[WORD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, div_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // keep the trial difference unless it went negative
            rem_next  = diff[WORD_W+1] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
            quo_next  = {quo_reg[WORD_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== sv/bbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbs_ctrl
// Scheduler state, command decode, result register and delay sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bbs_pkg::bbs_cfg_t cfg_regs,
    bbs_item_if.sink               items,
    bbs_result_if.source           results
);
    import bbs_pkg::*;

    bbs_state_t        state_reg, state_next;
    logic              enabled_reg, enabled_next;
    logic              armed_reg, armed_next;
    logic [SECS_W-1:0] secs_reg, secs_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic              busy_reg, busy_next;
    logic              was_tx_reg, was_tx_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_tx_reg, res_tx_next;
    logic              res_started_reg, res_started_next;
    logic              res_stopped_reg, res_stopped_next;
    logic [WORD_W-1:0] base_reg, base_next;

    logic              accept;
    logic [BCNT_W-1:0] bcnt_inc;
    bbs_div_req_t      div_req;
    bbs_div_rsp_t      div_rsp;

    bbs_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign items.ready = (state_reg == ST_IDLE) && (!res_valid_reg || results.ready);
    assign accept      = items.valid && items.ready;
    assign bcnt_inc    = bcnt_reg + BCNT_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        enabled_next     = enabled_reg;
        armed_next       = armed_reg;
        secs_next        = secs_reg;
        bcnt_next        = bcnt_reg;
        busy_next        = busy_reg;
        was_tx_next      = was_tx_reg;
        base_next        = base_reg;
        res_valid_next   = res_valid_reg && !results.ready;
        res_tx_next      = res_tx_reg;
        res_started_next = res_started_reg;
        res_stopped_next = res_stopped_reg;
        div_req.start    = 1'b0;
        div_req.dividend = items.random_word;
        div_req.divisor  = cfg_regs.backoff_span;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next   = 1'b1;
                    res_tx_next      = 1'b0;
                    res_started_next = 1'b0;
                    res_stopped_next = 1'b0;
                    unique case (items.cmd)
                        CMD_TICK:
                        begin
                            if (armed_reg)
                            begin
                                if (secs_reg <= SECS_W'(1))
                                begin
                                    armed_next = 1'b0;
                                    secs_next  = '0;
                                    if (busy_reg)
                                    begin
                                        bcnt_next = bcnt_inc;
                                        if (bcnt_inc > {1'b0, cfg_regs.max_backoffs})
                                        begin
                                            enabled_next     = 1'b0;
                                            bcnt_next        = '0;
                                            res_stopped_next = 1'b1;
                                        end
                                        else if (enabled_reg)
                                        begin
                                            // zero span behaves as one
                                            div_req.start   = 1'b1;
                                            div_req.divisor =
                                                (cfg_regs.backoff_span == '0) ?
                                                WORD_W'(1) : cfg_regs.backoff_span;
                                            base_next       = '0;
                                            state_next      = ST_DIV;
                                        end
                                    end
                                    else
                                    begin
                                        bcnt_next   = '0;
                                        res_tx_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    secs_next = secs_reg - SECS_W'(1);
                                end
                            end
                        end
                        CMD_START:
                        begin
                            enabled_next     = 1'b1;
                            armed_next       = 1'b1;
                            secs_next        = SECS_W'(1);
                            bcnt_next        = '0;
                            res_started_next = 1'b1;
                            res_stopped_next = 1'b1;
                        end
                        CMD_STOP:
                        begin
                            enabled_next     = 1'b0;
                            armed_next       = 1'b0;
                            secs_next        = '0;
                            bcnt_next        = '0;
                            res_stopped_next = 1'b1;
                        end
                        CMD_CHAN:
                        begin
                            busy_next = items.channel_busy;
                        end
                        CMD_TX:
                        begin
                            // idle delay only on the falling edge of transmitting
                            if (was_tx_reg && !items.transmitting && enabled_reg)
                            begin
                                if (cfg_regs.max_idle > cfg_regs.min_idle)
                                begin
                                    div_req.start   = 1'b1;
                                    div_req.divisor = cfg_regs.max_idle - cfg_regs.min_idle;
                                    base_next       = cfg_regs.min_idle;
                                    state_next      = ST_DIV;
                                end
                                else
                                begin
                                    armed_next = 1'b1;
                                    secs_next  = {1'b0, cfg_regs.min_idle};
                                end
                            end
                            was_tx_next = items.transmitting;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    armed_next = 1'b1;
                    secs_next  = {1'b0, base_reg} + {1'b0, div_rsp.rem};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enabled_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            secs_reg      <= '0;
            bcnt_reg      <= '0;
            busy_reg      <= 1'b0;
            was_tx_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enabled_reg   <= enabled_next;
            armed_reg     <= armed_next;
            secs_reg      <= secs_next;
            bcnt_reg      <= bcnt_next;
            busy_reg      <= busy_next;
            was_tx_reg    <= was_tx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg        <= base_next;
        res_tx_reg      <= res_tx_next;
        res_started_reg <= res_started_next;
        res_stopped_reg <= res_stopped_next;
    end

    assign results.valid        = res_valid_reg;
    assign results.transmit_now = res_tx_reg;
    assign results.started      = res_started_reg;
    assign results.stopped      = res_stopped_reg;

endmodule

`default_nettype wire
